[rtl/core/cffs_pkg.sv]
// Package for the coarse/fine focus search sequencer.
// Holds codes, phase and descriptor types, and reset values.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package cffs_pkg;

   localparam int POS_WIDTH_DEFAULT   = 16;
   localparam int SCORE_WIDTH_DEFAULT = 64;
   localparam int COUNT_WIDTH         = 18;
   localparam int ACTION_WIDTH        = 3;
   localparam int CMD_WIDTH           = 2;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int QUEUE_DEPTH         = 2;

   localparam int MIN_POS_RESET   = 0;
   localparam int MAX_POS_RESET   = 1023;
   localparam int START_POS_RESET = 0;
   localparam int STRIDE_RESET    = 16;

   localparam logic [CMD_WIDTH-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_PARK   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_POS   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_POS   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_POS = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIDE    = 8'd3;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_SAMPLE  = 3'd0,
      ACT_PARK    = 3'd1,
      ACT_RETURN  = 3'd2,
      ACT_DONE    = 3'd3,
      ACT_INVALID = 3'd4,
      ACT_FAILED  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_COARSE = 2'd1,
      PH_FINE   = 2'd2,
      PH_PARK   = 2'd3
   } phase_type;

   // single: one word; fail_pair: return word then failed word
   typedef enum logic {
      KIND_SINGLE    = 1'b0,
      KIND_FAIL_PAIR = 1'b1
   } desc_kind_type;

   typedef struct packed {
      logic push;
      logic full;
   } fq_wr_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } fq_rd_type;

endpackage

[rtl/core/cffs_if.sv]
// Channel interfaces for the focus search sequencer: request, response, csr write.
// Depends on cffs_pkg.
`timescale 1ns / 1ps

interface cffs_req_if #(
   parameter int SCORE_WIDTH = cffs_pkg::SCORE_WIDTH_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic [cffs_pkg::CMD_WIDTH-1:0]  cmd;
   logic                            report_ok;
   logic [SCORE_WIDTH-1:0]          score;

   modport source (output valid, cmd, report_ok, score, input ready);
   modport sink   (input valid, cmd, report_ok, score, output ready);
endinterface

interface cffs_rsp_if #(
   parameter int POS_WIDTH   = cffs_pkg::POS_WIDTH_DEFAULT,
   parameter int SCORE_WIDTH = cffs_pkg::SCORE_WIDTH_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [cffs_pkg::ACTION_WIDTH-1:0] action;
   logic signed [POS_WIDTH-1:0]       position;
   logic [SCORE_WIDTH-1:0]            best_value;
   logic [cffs_pkg::COUNT_WIDTH-1:0]  sample_total;
   logic                              last;

   modport source (output valid, action, position, best_value, sample_total, last,
                   input ready);
   modport sink   (input valid, action, position, best_value, sample_total, last,
                   output ready);
endinterface

interface cffs_csr_if #(
   parameter int POS_WIDTH = cffs_pkg::POS_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic [cffs_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [POS_WIDTH:0]                   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/cffs_front.sv]
// Front end: accepts request words, holds settings and search state,
// and pushes one result descriptor per word that produces output.
// Depends on cffs_pkg and cffs_if.
`timescale 1ns / 1ps

module cffs_front #(
   parameter int POS_WIDTH   = cffs_pkg::POS_WIDTH_DEFAULT,
   parameter int SCORE_WIDTH = cffs_pkg::SCORE_WIDTH_DEFAULT,
   parameter int DESC_WIDTH  = 1 + cffs_pkg::ACTION_WIDTH + POS_WIDTH + SCORE_WIDTH
                               + cffs_pkg::COUNT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   cffs_req_if.sink             req_ch,
   cffs_csr_if.sink             csr_ch,
   output cffs_pkg::fq_wr_type  wr_ctl,
   input  logic                 q_full,
   output logic [DESC_WIDTH-1:0] desc
);
   import cffs_pkg::*;

   localparam int EW = POS_WIDTH + 3;   // room for +/- stride and span

   // settings
   logic signed [POS_WIDTH-1:0] min_ff, max_ff, start_ff;
   logic [POS_WIDTH:0]          stride_ff;

   // search state
   phase_type                   phase_ff, phase_in;
   logic signed [POS_WIDTH-1:0] scan_ff, scan_in;
   logic [SCORE_WIDTH-1:0]      top_score_ff, top_score_in;
   logic signed [POS_WIDTH-1:0] top_pos_ff, top_pos_in;
   logic                        top_valid_ff, top_valid_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic signed [POS_WIDTH-1:0] fine_end_ff, fine_end_in;

   logic accept;
   logic is_start, is_sample, is_park, ok;
   logic signed [EW-1:0] min_e, max_e, start_e, stride_e, span_e, scan_e, top_e;
   logic signed [EW-1:0] fine_end_e, ntop_e, lo_e, hi_e, lo_c, hi_c, rem_e, step_e;
   logic signed [EW-1:0] d_scan, d_top;
   logic [EW-1:0]        a_scan, a_top;
   logic cfg_bad, win, coarse_end, fine_empty, fine_done, step_clamp;
   logic signed [POS_WIDTH-1:0] ntop_pos;

   logic                        push;
   desc_kind_type               d_kind;
   action_type                  d_act;
   logic signed [POS_WIDTH-1:0] d_pos;
   logic [SCORE_WIDTH-1:0]      d_best;
   logic [COUNT_WIDTH-1:0]      d_cnt;

   assign req_ch.ready = !q_full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && !q_full;
   assign ok           = req_ch.report_ok;

   assign is_start  = req_ch.cmd == CMD_START;
   assign is_sample = (req_ch.cmd == CMD_SAMPLE) && (phase_ff == PH_COARSE ||
                                                      phase_ff == PH_FINE);
   assign is_park   = (req_ch.cmd == CMD_PARK) && (phase_ff == PH_PARK);

   assign min_e      = {{3{min_ff[POS_WIDTH-1]}}, min_ff};
   assign max_e      = {{3{max_ff[POS_WIDTH-1]}}, max_ff};
   assign start_e    = {{3{start_ff[POS_WIDTH-1]}}, start_ff};
   assign scan_e     = {{3{scan_ff[POS_WIDTH-1]}}, scan_ff};
   assign top_e      = {{3{top_pos_ff[POS_WIDTH-1]}}, top_pos_ff};
   assign fine_end_e = {{3{fine_end_ff[POS_WIDTH-1]}}, fine_end_ff};
   assign stride_e   = {2'b00, stride_ff};
   assign span_e     = max_e - min_e + EW'(1);

   assign cfg_bad = (min_e > max_e) || (start_e < min_e) || (start_e > max_e) ||
                    (stride_e == '0) || (stride_e > span_e);

   // tie-break: distance to start
   assign d_scan = scan_e - start_e;
   assign d_top  = top_e - start_e;
   assign a_scan = (d_scan < 0) ? EW'(-d_scan) : EW'(d_scan);
   assign a_top  = (d_top < 0) ? EW'(-d_top) : EW'(d_top);

   assign win = !top_valid_ff || (req_ch.score > top_score_ff) ||
                ((req_ch.score == top_score_ff) && (a_scan < a_top));

   assign ntop_pos = win ? scan_ff : top_pos_ff;
   assign ntop_e   = {{3{ntop_pos[POS_WIDTH-1]}}, ntop_pos};

   // fine window around the coarse best, clamped to the range
   assign lo_e       = ntop_e - stride_e;
   assign hi_e       = ntop_e + stride_e;
   assign lo_c       = (lo_e < min_e) ? min_e : lo_e;
   assign hi_c       = (hi_e > max_e) ? max_e : hi_e;
   assign fine_empty = lo_c > hi_c;

   assign coarse_end = (phase_ff == PH_COARSE) && (scan_ff == max_ff);
   assign fine_done  = (phase_ff == PH_FINE) && (scan_e >= fine_end_e);
   assign rem_e      = max_e - scan_e;
   assign step_clamp = rem_e <= stride_e;
   assign step_e     = scan_e + stride_e;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         priority if (is_start) begin
            phase_in = cfg_bad ? PH_IDLE : PH_COARSE;
         end else if (is_sample) begin
            priority if (!ok)       phase_in = PH_IDLE;
            else if (coarse_end)    phase_in = fine_empty ? PH_PARK : PH_FINE;
            else if (fine_done)     phase_in = PH_PARK;
            else                    phase_in = phase_ff;
         end else if (is_park) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = phase_ff;
         end
      end
   end

   // data path and descriptor
   always_comb begin
      scan_in      = scan_ff;
      top_score_in = top_score_ff;
      top_pos_in   = top_pos_ff;
      top_valid_in = top_valid_ff;
      count_in     = count_ff;
      fine_end_in  = fine_end_ff;
      push         = 1'b0;
      d_kind       = KIND_SINGLE;
      d_act        = ACT_SAMPLE;
      d_pos        = '0;
      d_best       = '0;
      d_cnt        = '0;
      if (accept) begin
         priority if (is_start) begin
            push = 1'b1;
            if (cfg_bad) begin
               d_act = ACT_INVALID;
            end else begin
               scan_in      = min_ff;
               top_score_in = '0;
               top_pos_in   = start_ff;
               top_valid_in = 1'b0;
               count_in     = '0;
               d_act        = ACT_SAMPLE;
               d_pos        = min_ff;
            end
         end else if (is_sample) begin
            push = 1'b1;
            if (!ok) begin
               d_kind = KIND_FAIL_PAIR;
               d_pos  = start_ff;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
               if (win) begin
                  top_score_in = req_ch.score;
                  top_pos_in   = scan_ff;
                  top_valid_in = 1'b1;
               end
               priority if (coarse_end) begin
                  top_valid_in = 1'b0;
                  if (fine_empty) begin
                     d_act = ACT_PARK;
                     d_pos = ntop_pos;
                  end else begin
                     scan_in     = lo_c[POS_WIDTH-1:0];
                     fine_end_in = hi_c[POS_WIDTH-1:0];
                     d_pos       = lo_c[POS_WIDTH-1:0];
                  end
               end else if (phase_ff == PH_COARSE) begin
                  scan_in = step_clamp ? max_ff : step_e[POS_WIDTH-1:0];
                  d_pos   = step_clamp ? max_ff : step_e[POS_WIDTH-1:0];
               end else if (fine_done) begin
                  d_act = ACT_PARK;
                  d_pos = ntop_pos;
               end else begin
                  scan_in = scan_ff + POS_WIDTH'(1);
                  d_pos   = scan_ff + POS_WIDTH'(1);
               end
            end
         end else if (is_park) begin
            push = 1'b1;
            if (!ok) begin
               d_kind = KIND_FAIL_PAIR;
               d_pos  = start_ff;
            end else begin
               d_act  = ACT_DONE;
               d_pos  = top_pos_ff;
               d_best = top_score_ff;
               d_cnt  = count_ff;
            end
         end else begin
            push = 1'b0;
         end
      end
   end

   assign wr_ctl.push = push;
   assign wr_ctl.full = q_full;
   assign desc        = {d_kind, d_act, d_pos, d_best, d_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= POS_WIDTH'(MIN_POS_RESET);
         max_ff       <= POS_WIDTH'(MAX_POS_RESET);
         start_ff     <= POS_WIDTH'(START_POS_RESET);
         stride_ff    <= (POS_WIDTH + 1)'(STRIDE_RESET);
         phase_ff     <= PH_IDLE;
         scan_ff      <= '0;
         top_score_ff <= '0;
         top_pos_ff   <= '0;
         top_valid_ff <= 1'b0;
         count_ff     <= '0;
         fine_end_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         scan_ff      <= scan_in;
         top_score_ff <= top_score_in;
         top_pos_ff   <= top_pos_in;
         top_valid_ff <= top_valid_in;
         count_ff     <= count_in;
         fine_end_ff  <= fine_end_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_MIN_POS:   min_ff    <= csr_ch.data[POS_WIDTH-1:0];
               CSR_MAX_POS:   max_ff    <= csr_ch.data[POS_WIDTH-1:0];
               CSR_START_POS: start_ff  <= csr_ch.data[POS_WIDTH-1:0];
               CSR_STRIDE:    stride_ff <= csr_ch.data;
               default:       ;
            endcase
         end
      end
   end

endmodule

[rtl/core/cffs_queue.sv]
// Short descriptor queue between front and back ends.
// Depends on cffs_pkg.
`timescale 1ns / 1ps

module cffs_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cffs_pkg::fq_wr_type   wr_ctl,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  full,
   input  logic                  pop,
   output cffs_pkg::fq_rd_type   rd_ctl,
   output logic [DATA_WIDTH-1:0] rd_data
);
   import cffs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  do_push, do_pop, empty;

   assign full    = cnt_ff == CW'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = wr_ctl.push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   assign rd_ctl.pop   = do_pop;
   assign rd_ctl.empty = empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[rtl/core/cffs_back.sv]
// Back end: expands queued descriptors into response words.
// A failure descriptor becomes a return word followed by a failed word.
// Depends on cffs_pkg and cffs_if.
`timescale 1ns / 1ps

module cffs_back #(
   parameter int POS_WIDTH   = cffs_pkg::POS_WIDTH_DEFAULT,
   parameter int SCORE_WIDTH = cffs_pkg::SCORE_WIDTH_DEFAULT,
   parameter int DESC_WIDTH  = 1 + cffs_pkg::ACTION_WIDTH + POS_WIDTH + SCORE_WIDTH
                               + cffs_pkg::COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cffs_pkg::fq_rd_type   rd_ctl,
   input  logic [DESC_WIDTH-1:0] desc,
   output logic                  pop,
   cffs_rsp_if.source            rsp_ch
);
   import cffs_pkg::*;

   logic                        h_kind;
   logic [ACTION_WIDTH-1:0]     h_act;
   logic signed [POS_WIDTH-1:0] h_pos;
   logic [SCORE_WIDTH-1:0]      h_best;
   logic [COUNT_WIDTH-1:0]      h_cnt;
   desc_kind_type               kind;
   logic                        second_ff, second_in;
   logic                        taken;

   assign {h_kind, h_act, h_pos, h_best, h_cnt} = desc;
   assign kind  = desc_kind_type'(h_kind);
   assign taken = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      rsp_ch.valid        = !rd_ctl.empty;
      rsp_ch.action       = h_act;
      rsp_ch.position     = h_pos;
      rsp_ch.best_value   = h_best;
      rsp_ch.sample_total = h_cnt;
      rsp_ch.last         = 1'b1;
      pop                 = taken;
      second_in           = second_ff;
      unique case (kind)
         KIND_SINGLE: begin
            second_in = 1'b0;
         end
         KIND_FAIL_PAIR: begin
            rsp_ch.best_value   = '0;
            rsp_ch.sample_total = '0;
            if (second_ff) begin
               rsp_ch.action   = ACT_FAILED;
               rsp_ch.position = '0;
               if (taken) second_in = 1'b0;
            end else begin
               rsp_ch.action = ACT_RETURN;
               rsp_ch.last   = 1'b0;
               pop           = 1'b0;
               if (taken) second_in = 1'b1;
            end
         end
         default: second_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

[rtl/core/coarse_fine_focus_search.sv]
// Top level of the coarse/fine lens focus search sequencer.
// Instantiates cffs_front, cffs_queue and cffs_back; depends on cffs_pkg, cffs_if.
//
// Usage:
//  - req_ch: request words (cmd start / sample report / park report, report_ok,
//    score). One word accepted per cycle while the descriptor queue has room.
//  - rsp_ch: response words (action, position, best_value, sample_total, last).
//    Start, sample and park words each give one response; a failed report gives
//    a return request (last=0) and then a failed word (last=1). Words that do not
//    fit the current phase give nothing.
//  - csr_ch: register writes (index 0 min, 1 max, 2 start, 3 stride), always
//    ready, applied the cycle after the handshake.
// Responses: each descriptor is registered in the queue, and rsp_ch offers it from there.
// Throughput: one request word per cycle while the queue has room, set by
//   the front end's state update (one 64-bit score compare plus position
//   arithmetic); a failure gives two response words from one descriptor.
// Stalls: when rsp_ch is held off, descriptors collect in the 2-entry queue and
//   req_ch.ready drops only once it is full.
// Reset: synchronous; settings return to min 0, max 1023, start 0, stride 16,
//   phase idle, queue empty.
`timescale 1ns / 1ps

module coarse_fine_focus_search #(
   parameter int POS_WIDTH   = cffs_pkg::POS_WIDTH_DEFAULT,
   parameter int SCORE_WIDTH = cffs_pkg::SCORE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   cffs_req_if.sink     req_ch,
   cffs_rsp_if.source   rsp_ch,
   cffs_csr_if.sink     csr_ch
);
   import cffs_pkg::*;

   // descriptor word: kind, action, position, score, count
   localparam int DESC_WIDTH = 1 + ACTION_WIDTH + POS_WIDTH + SCORE_WIDTH + COUNT_WIDTH;

   fq_wr_type               wr_ctl;
   fq_rd_type               rd_ctl;
   logic                    q_full;
   logic                    pop;
   logic [DESC_WIDTH-1:0]   wr_desc;
   logic [DESC_WIDTH-1:0]   rd_desc;

   // front: classify and update search state
   cffs_front #(
      .POS_WIDTH   (POS_WIDTH),
      .SCORE_WIDTH (SCORE_WIDTH),
      .DESC_WIDTH  (DESC_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .wr_ctl (wr_ctl),
      .q_full (q_full),
      .desc   (wr_desc)
   );

   // queue decouples request acceptance from response stalls
   cffs_queue #(
      .DATA_WIDTH (DESC_WIDTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_ctl  (wr_ctl),
      .wr_data (wr_desc),
      .full    (q_full),
      .pop     (pop),
      .rd_ctl  (rd_ctl),
      .rd_data (rd_desc)
   );

   // back: expand descriptors into response words
   cffs_back #(
      .POS_WIDTH   (POS_WIDTH),
      .SCORE_WIDTH (SCORE_WIDTH),
      .DESC_WIDTH  (DESC_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .rd_ctl (rd_ctl),
      .desc   (rd_desc),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
